### hw/rtl/single_wire_humidity_sensor_reader_defines.svh
// Assertion macros used by the checker file of the sensor reader.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define SWHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SWHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/swhs_pkg.sv
// Package: shared constants and types of the single-wire sensor reader.
package swhs_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int REG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int FRAME_BITS        = 40;
  localparam int BIT_IDX_W         = 6;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_CHK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SAMPLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT  = 3'd4;

  // Register reset values
  localparam logic [REG_W-1:0] START_LOW_RST     = 16'd1000;
  localparam logic [REG_W-1:0] RELEASE_HIGH_RST  = 16'd30;
  localparam logic [REG_W-1:0] RESPONSE_CHK_RST  = 16'd80;
  localparam logic [REG_W-1:0] BIT_SAMPLE_RST    = 16'd40;
  localparam logic [REG_W-1:0] EDGE_TIMEOUT_RST  = 16'd20000;

  typedef struct packed {
    logic [REG_W-1:0] start_low_us;
    logic [REG_W-1:0] release_high_us;
    logic [REG_W-1:0] response_check_us;
    logic [REG_W-1:0] bit_sample_us;
    logic [REG_W-1:0] edge_timeout_us;
  } swhs_cfg_t;

  typedef struct packed {
    logic               drive_enable;
    logic               drive_level;
    logic               busy_res;
    logic               done_res;
    logic               no_response;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } swhs_res_t;

endpackage

### hw/rtl/swhs_ifs.sv
// Interfaces: input, result and configuration channels of the sensor reader.
interface swhs_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic line_level;
  modport source (output valid, output cmd, output line_level, input ready);
  modport sink   (input valid, input cmd, input line_level, output ready);
endinterface

interface swhs_out_if;
  logic               valid;
  logic               ready;
  logic               drive_enable;
  logic               drive_level;
  logic               busy_res;
  logic               done_res;
  logic               no_response;
  logic [15:0]        humidity_tenths;
  logic signed [15:0] temperature_tenths;
  modport source (output valid, output drive_enable, output drive_level, output busy_res,
                  output done_res, output no_response, output humidity_tenths,
                  output temperature_tenths, input ready);
  modport sink   (input valid, input drive_enable, input drive_level, input busy_res,
                  input done_res, input no_response, input humidity_tenths,
                  input temperature_tenths, output ready);
endinterface

interface swhs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swhs_pkg::CFG_IDX_W-1:0] index;
  logic [swhs_pkg::REG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/swhs_cfg_regs.sv
// Configuration register file: five 16-bit timing registers.
module swhs_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  swhs_cfg_if.sink            cfg_ch,
  output swhs_pkg::swhs_cfg_t cfg
);

  swhs_pkg::swhs_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us      <= swhs_pkg::START_LOW_RST;
      cfg_r.release_high_us   <= swhs_pkg::RELEASE_HIGH_RST;
      cfg_r.response_check_us <= swhs_pkg::RESPONSE_CHK_RST;
      cfg_r.bit_sample_us     <= swhs_pkg::BIT_SAMPLE_RST;
      cfg_r.edge_timeout_us   <= swhs_pkg::EDGE_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        swhs_pkg::CFG_START_LOW:    cfg_r.start_low_us      <= cfg_ch.data;
        swhs_pkg::CFG_RELEASE_HIGH: cfg_r.release_high_us   <= cfg_ch.data;
        swhs_pkg::CFG_RESPONSE_CHK: cfg_r.response_check_us <= cfg_ch.data;
        swhs_pkg::CFG_BIT_SAMPLE:   cfg_r.bit_sample_us     <= cfg_ch.data;
        swhs_pkg::CFG_EDGE_TIMEOUT: cfg_r.edge_timeout_us   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/swhs_ctrl.sv
// Read sequencer: phase state, delay counter, bit shifter and value holds.
module swhs_ctrl #(
  parameter int COUNTER_WIDTH = swhs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                cmd,
  input  logic                line_level,
  input  swhs_pkg::swhs_cfg_t cfg,
  output swhs_pkg::swhs_res_t res
);

  localparam int LW = (COUNTER_WIDTH > swhs_pkg::REG_W) ? COUNTER_WIDTH : swhs_pkg::REG_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
  localparam logic [LW-1:0]            MAX_EXT = LW'(CNT_MAX);
  localparam logic [swhs_pkg::BIT_IDX_W-1:0] LAST_BIT =
    swhs_pkg::BIT_IDX_W'(swhs_pkg::FRAME_BITS);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LOW, PH_HIGH, PH_WAIT_LOW, PH_RESP_DELAY,
    PH_TAIL_LOW, PH_BIT_RISE, PH_BIT_DELAY, PH_BIT_FALL
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [COUNTER_WIDTH-1:0]       cnt_r, cnt_nxt, cnt_inc;
  logic [swhs_pkg::BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt, bit_inc;
  logic [swhs_pkg::FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                           resp_r, resp_nxt;
  logic [15:0]                    hum_r, hum_nxt;
  logic [15:0]                    temp_r, temp_nxt;
  logic [15:0]                    raw_temp;
  logic [swhs_pkg::REG_W-1:0]     lim_sel;
  logic [LW-1:0]                  lim_ext, lim;
  logic                           reach;
  logic                           done, nores;

  // Saturating tick count and the limit of the current phase
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign bit_inc = bit_idx_r + 1'b1;
  assign raw_temp = frame_r[23:8];

  always_comb begin
    case (phase_r)
      PH_LOW:        lim_sel = cfg.start_low_us;
      PH_HIGH:       lim_sel = cfg.release_high_us;
      PH_RESP_DELAY: lim_sel = cfg.response_check_us;
      PH_BIT_DELAY:  lim_sel = cfg.bit_sample_us;
      default:       lim_sel = cfg.edge_timeout_us;
    endcase
  end

  assign lim_ext = LW'(lim_sel);
  assign lim     = (lim_ext > MAX_EXT) ? MAX_EXT : lim_ext;
  assign reach   = LW'(cnt_inc) >= lim;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    bit_idx_nxt = bit_idx_r;
    frame_nxt   = frame_r;
    resp_nxt    = resp_r;
    hum_nxt     = hum_r;
    temp_nxt    = temp_r;
    done        = 1'b0;
    nores       = 1'b0;
    if (step) begin
      if (cmd) begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_LOW;
          cnt_nxt   = '0;
        end
      end else begin
        case (phase_r)
          PH_IDLE: ;
          PH_LOW: begin
            cnt_nxt = reach ? '0 : cnt_inc;
            if (reach) phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            cnt_nxt = reach ? '0 : cnt_inc;
            if (reach) phase_nxt = PH_WAIT_LOW;
          end
          PH_WAIT_LOW: begin
            if (!line_level) begin
              phase_nxt = PH_RESP_DELAY;
              cnt_nxt   = '0;
            end else if (reach) begin
              resp_nxt  = 1'b0;
              phase_nxt = PH_TAIL_LOW;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_RESP_DELAY: begin
            cnt_nxt = reach ? '0 : cnt_inc;
            if (reach) begin
              resp_nxt  = line_level;
              phase_nxt = PH_TAIL_LOW;
            end
          end
          PH_TAIL_LOW: begin
            if (!line_level || reach) begin
              cnt_nxt = '0;
              if (resp_r) begin
                bit_idx_nxt = '0;
                frame_nxt   = '0;
                phase_nxt   = PH_BIT_RISE;
              end else begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                nores     = 1'b1;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_BIT_RISE: begin
            cnt_nxt = (line_level || reach) ? '0 : cnt_inc;
            if (line_level || reach) phase_nxt = PH_BIT_DELAY;
          end
          PH_BIT_DELAY: begin
            cnt_nxt = reach ? '0 : cnt_inc;
            if (reach) begin
              frame_nxt = {frame_r[swhs_pkg::FRAME_BITS-2:0], line_level};
              phase_nxt = PH_BIT_FALL;
            end
          end
          PH_BIT_FALL: begin
            if (!line_level || reach) begin
              cnt_nxt = '0;
              if (bit_inc >= LAST_BIT) begin
                // Frame complete: humidity from bytes 0-1, temperature from 2-3
                hum_nxt     = frame_r[39:24];
                temp_nxt    = raw_temp[15] ? 16'(16'd0 - {1'b0, raw_temp[14:0]}) : raw_temp;
                bit_idx_nxt = '0;
                phase_nxt   = PH_IDLE;
                done        = 1'b1;
              end else begin
                bit_idx_nxt = bit_inc;
                phase_nxt   = PH_BIT_RISE;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      bit_idx_r <= '0;
      frame_r   <= '0;
      resp_r    <= 1'b0;
      hum_r     <= '0;
      temp_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      bit_idx_r <= bit_idx_nxt;
      frame_r   <= frame_nxt;
      resp_r    <= resp_nxt;
      hum_r     <= hum_nxt;
      temp_r    <= temp_nxt;
    end
  end

  // Result shows the state after this item
  always_comb begin
    res.drive_enable       = (phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH);
    res.drive_level        = (phase_nxt == PH_HIGH);
    res.busy_res           = (phase_nxt != PH_IDLE);
    res.done_res           = done;
    res.no_response        = nores;
    res.humidity_tenths    = hum_nxt;
    res.temperature_tenths = temp_nxt;
  end

endmodule

### hw/rtl/single_wire_humidity_sensor_reader.sv
// Top level: single-wire humidity/temperature sensor reader.
//
// Usage:
//  - in_ch carries one item per microsecond: cmd = 0 is a tick with the
//    sampled data-line level, cmd = 1 starts a read (ignored while busy).
//  - out_ch returns exactly one item per input item: line drive controls,
//    busy/done/no_response flags and the last good humidity and temperature
//    in tenths (temperature two's complement).
//  - cfg_ch writes the five timing registers (index 0..4); it is always
//    ready. Write only while no items are in flight.
// Pipeline:
//  - An item lands in the input register, then one pass of sequencer logic
//    updates the state and loads the result register that drives out_ch.valid.
//  - Throughput is one item per cycle while out_ch.ready is high; the sequencer
//    state update is the only loop in the data path.
// Stall: while out_ch.ready is low the result holds and the input register
//  keeps one item, so in_ch.ready drops only when both stages are full.
// Reset (rst_n low, synchronous): registers to defaults, sequencer idle,
//  held values cleared, both stages emptied.
module single_wire_humidity_sensor_reader #(
  parameter int COUNTER_WIDTH = swhs_pkg::COUNTER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swhs_in_if.sink     in_ch,
  swhs_out_if.source  out_ch,
  swhs_cfg_if.sink    cfg_ch
);

  swhs_pkg::swhs_cfg_t cfg;
  swhs_pkg::swhs_res_t res;
  swhs_pkg::swhs_res_t res_r;

  logic s1_valid_r;
  logic s1_cmd_r;
  logic s1_lvl_r;
  logic out_valid_r;
  logic advance;

  // Item in the input register moves on when the result slot is free
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  swhs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  swhs_ctrl #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .cmd        (s1_cmd_r),
    .line_level (s1_lvl_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r <= in_ch.cmd;
      s1_lvl_r <= in_ch.line_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.drive_enable       = res_r.drive_enable;
  assign out_ch.drive_level        = res_r.drive_level;
  assign out_ch.busy_res           = res_r.busy_res;
  assign out_ch.done_res           = res_r.done_res;
  assign out_ch.no_response        = res_r.no_response;
  assign out_ch.humidity_tenths    = res_r.humidity_tenths;
  assign out_ch.temperature_tenths = res_r.temperature_tenths;

endmodule

### hw/rtl/swhs_chk.sv
// Checker: port-level assertions on the sensor reader, bound to the top level.
`include "single_wire_humidity_sensor_reader_defines.svh"

module swhs_chk (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic drive_enable,
  input logic drive_level,
  input logic busy_res,
  input logic done_res,
  input logic no_response
);

  `SWHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SWHS_ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res, "done while still busy")
  `SWHS_ASSERT_IMPLY(a_nores_done, clk, rst_n, out_valid && no_response, done_res, "no_response without done")
  `SWHS_ASSERT_IMPLY(a_drive_busy, clk, rst_n, out_valid && drive_enable, busy_res && !done_res, "line driven outside a read")
  `SWHS_ASSERT_IMPLY(a_level_en, clk, rst_n, out_valid && drive_level, drive_enable, "drive level high while released")

endmodule

bind single_wire_humidity_sensor_reader swhs_chk u_swhs_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .drive_enable (out_ch.drive_enable),
  .drive_level  (out_ch.drive_level),
  .busy_res     (out_ch.busy_res),
  .done_res     (out_ch.done_res),
  .no_response  (out_ch.no_response)
);
